// ===== hdl/mfi_pkg.sv =====
// Shared types and constants for the motion-JPEG frame indexer.
package mfi_pkg;

    localparam logic [7:0]  MARK_LEAD   = 8'hFF;
    localparam logic [7:0]  MARK_SOI    = 8'hD8;
    localparam logic [7:0]  MARK_EOI    = 8'hD9;
    localparam logic [15:0] LIMIT_RESET = 16'd900;
    localparam logic [31:0] POS_MAX     = 32'hFFFF_FFFF;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_TOO_MANY     = 3'd1;
    localparam logic [2:0] ST_UNTERMINATED = 3'd2;
    localparam logic [2:0] ST_NO_FRAMES    = 3'd3;
    localparam logic [2:0] ST_TOO_LONG     = 3'd4;

    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic        kind;
        logic [31:0] frame_offset;
        logic [31:0] frame_length;
        logic [15:0] frame_number;
        logic [2:0]  status;
        logic [15:0] total_frames;
        logic [31:0] largest_length;
        logic        last_of_run;
    } t_result;

    // Results produced by one byte: none, one or two, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_scan_out;

endpackage

// ===== hdl/mfi_scanner.sv =====
// Input register, marker scan state and result formation.
module mfi_scanner (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_stream,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data,
    input  logic              i_room,
    output mfi_pkg::t_scan_out o_scan
);
    import mfi_pkg::*;

    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_byte;
    logic        r_eos;
    logic [15:0] r_limit;

    logic [7:0]  r_prior,   n_prior;
    logic        r_inside,  n_inside;
    logic [31:0] r_pos,     n_pos;
    logic [31:0] r_start,   n_start;
    logic [15:0] r_found,   n_found;
    logic [31:0] r_largest, n_largest;
    logic [2:0]  r_fail,    n_fail;

    logic        advance;
    logic        accept;
    logic        rec_v;
    logic [31:0] len;
    logic [2:0]  st;
    t_result     rec;
    t_result     sum;

    assign advance = r_in_valid && i_room;
    assign o_stall = r_in_valid && !i_room;
    assign accept  = i_valid && !o_stall;
    assign len     = r_pos + 32'd1 - r_start;

    always_comb begin
        n_in_valid = accept ? 1'b1 : (advance ? 1'b0 : r_in_valid);
    end

    always_comb begin
        n_prior   = r_prior;
        n_inside  = r_inside;
        n_pos     = r_pos;
        n_start   = r_start;
        n_found   = r_found;
        n_largest = r_largest;
        n_fail    = r_fail;
        rec_v     = 1'b0;
        if (r_pos == POS_MAX) begin
            n_fail = ST_TOO_LONG;
        end else begin
            if (r_fail == ST_OK) begin
                if (!r_inside && r_prior == MARK_LEAD && r_byte == MARK_SOI) begin
                    n_start  = r_pos - 32'd1;
                    n_inside = 1'b1;
                end else if (r_inside && r_prior == MARK_LEAD && r_byte == MARK_EOI) begin
                    if (r_found < r_limit) begin
                        rec_v   = 1'b1;
                        n_found = r_found + 16'd1;
                        if (len > r_largest) begin
                            n_largest = len;
                        end
                    end else begin
                        n_fail = ST_TOO_MANY;
                    end
                    n_inside = 1'b0;
                end
                n_prior = r_byte;
            end
            n_pos = r_pos + 32'd1;
        end

        // Status by priority, taken from the state after this byte.
        if (n_fail == ST_TOO_LONG) begin
            st = ST_TOO_LONG;
        end else if (n_fail == ST_TOO_MANY) begin
            st = ST_TOO_MANY;
        end else if (n_inside) begin
            st = ST_UNTERMINATED;
        end else if (n_found == 16'd0) begin
            st = ST_NO_FRAMES;
        end else begin
            st = ST_OK;
        end

        rec                = '0;
        rec.kind           = KIND_RECORD;
        rec.frame_offset   = r_start;
        rec.frame_length   = len;
        rec.frame_number   = r_found;
        rec.last_of_run    = !r_eos;

        sum                = '0;
        sum.kind           = KIND_SUMMARY;
        sum.status         = st;
        sum.total_frames   = n_found;
        sum.largest_length = n_largest;
        sum.last_of_run    = 1'b1;

        o_scan = '0;
        if (advance) begin
            if (rec_v) begin
                o_scan.first  = rec;
                o_scan.second = sum;
                o_scan.count  = r_eos ? 2'd2 : 2'd1;
            end else if (r_eos) begin
                o_scan.first = sum;
                o_scan.count = 2'd1;
            end
        end

        // Return to the reset state once the summary is out.
        if (r_eos) begin
            n_prior   = '0;
            n_inside  = 1'b0;
            n_pos     = '0;
            n_start   = '0;
            n_found   = '0;
            n_largest = '0;
            n_fail    = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_limit    <= LIMIT_RESET;
            r_prior    <= '0;
            r_inside   <= 1'b0;
            r_pos      <= '0;
            r_start    <= '0;
            r_found    <= '0;
            r_largest  <= '0;
            r_fail     <= ST_OK;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (advance) begin
                r_prior   <= n_prior;
                r_inside  <= n_inside;
                r_pos     <= n_pos;
                r_start   <= n_start;
                r_found   <= n_found;
                r_largest <= n_largest;
                r_fail    <= n_fail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_data_byte;
            r_eos  <= i_end_of_stream;
        end
    end

endmodule

// ===== hdl/mfi_result_fifo.sv =====
// Small result queue taking up to two results a beat and giving one.
module mfi_result_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mfi_pkg::t_scan_out i_scan,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_stall,
    output mfi_pkg::t_result   o_head
);
    import mfi_pkg::*;

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count,  n_count;
    logic                   pop;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;
    // Room for a full pair of results, judged on the registered fill.
    assign o_room  = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(i_scan.count);
        n_rd_ptr = r_rd_ptr + FIFO_PTR_W'(pop);
        n_count  = r_count + FIFO_CNT_W'(i_scan.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_scan.first;
        end
        if (i_scan.count == 2'd2) begin
            r_mem[r_wr_ptr + FIFO_PTR_W'(1)] <= i_scan.second;
        end
    end

endmodule

// ===== hdl/mjpeg_frame_indexer_unit.sv =====
// Top level of the motion-JPEG frame indexer: scanner and result queue.
// Path: a byte beat is captured in the input register; its results are written into the
// result queue once it has room for a pair, and the queue head offers the first result.
// Throughput: one byte per cycle while each byte gives at most one result and the queue has
// room for a pair; a record and a summary from one byte are drained one per unstalled cycle.
// Reset (i_rst_n low, synchronous): scan state cleared, queue empty, frame_limit back to 900.
module mjpeg_frame_indexer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    // frame_limit register
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [31:0] o_frame_offset,
    output logic [31:0] o_frame_length,
    output logic [15:0] o_frame_number,
    output logic [2:0]  o_status,
    output logic [15:0] o_total_frames,
    output logic [31:0] o_largest_length,
    output logic        o_last_of_run
);
    import mfi_pkg::*;

    t_scan_out scan;
    t_result   head;
    logic      room;

    // Scanner: holds one byte beat, advances it when the queue can take a pair.
    mfi_scanner u_scanner (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_room          (room),
        .o_scan          (scan)
    );

    // Result queue: parts the scanner from output stalls.
    mfi_result_fifo u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (scan),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_head  (head)
    );

    // Unpack the head of the queue onto the result ports.
    assign o_result_kind    = head.kind;
    assign o_frame_offset   = head.frame_offset;
    assign o_frame_length   = head.frame_length;
    assign o_frame_number   = head.frame_number;
    assign o_status         = head.status;
    assign o_total_frames   = head.total_frames;
    assign o_largest_length = head.largest_length;
    assign o_last_of_run    = head.last_of_run;

endmodule

// ===== hdl/mfi_checker.sv =====
// Port-level checks for the frame indexer and their bind to the top level.
module mfi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_data_byte,
    input logic        i_end_of_stream,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_result_kind,
    input logic [31:0] o_frame_offset,
    input logic [31:0] o_frame_length,
    input logic [15:0] o_frame_number,
    input logic [2:0]  o_status,
    input logic [15:0] o_total_frames,
    input logic [31:0] o_largest_length,
    input logic        o_last_of_run
);
    import mfi_pkg::*;

    // Hold a stalled byte beat.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_valid && o_stall) |->
            i_valid && $stable(i_data_byte) && $stable(i_end_of_stream))
        else $error("stalled byte beat changed");

    // Hold a stalled result beat.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_valid && i_stall) |->
            o_valid && $stable(o_frame_offset) && $stable(o_frame_length)
            && $stable(o_frame_number) && $stable(o_result_kind) && $stable(o_status))
        else $error("stalled result beat changed");

    // A summary always closes the run of its byte.
    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_SUMMARY |-> o_last_of_run)
        else $error("summary without last_of_run");

    // A frame record spans at least both markers.
    a_rec_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_RECORD |->
            o_frame_length >= 32'd4 && o_status == ST_OK && o_total_frames == 16'd0)
        else $error("malformed frame record");

    // No frames means an empty count and no largest length.
    a_no_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_SUMMARY && o_status == ST_NO_FRAMES |->
            o_total_frames == 16'd0 && o_largest_length == 32'd0)
        else $error("no-frames summary with frames counted");

endmodule

bind mjpeg_frame_indexer_unit mfi_checker u_mfi_checker (.*);
